// ===== hdl/mscc_pkg.sv =====
// ----------------------------------------------------------------------------
// mscc_pkg
// Types, widths and edge selection shared by the contour endpoint block.
// ----------------------------------------------------------------------------
package mscc_pkg;

    localparam int CORNER_W  = 16;
    localparam int BIAS_W    = 13;
    localparam int SUM_W     = CORNER_W + 1;
    localparam int IDX_W     = 12;
    localparam int FRAC_BITS = 12;
    localparam int FRAC_W    = FRAC_BITS + 1;
    localparam int NUM_W     = CORNER_W;
    localparam int DEN_W     = SUM_W;

    localparam logic [FRAC_W-1:0] FRAC_ONE  = FRAC_W'(1) << FRAC_BITS;
    localparam logic [FRAC_W-1:0] FRAC_ZERO = '0;

    localparam int CELL_QUEUE_DEPTH  = 4;
    localparam int POINT_QUEUE_DEPTH = 32;

    typedef enum logic [1:0] {
        EDGE_LEFT,
        EDGE_BOTTOM,
        EDGE_RIGHT,
        EDGE_TOP
    } edge_t;

    typedef struct packed {
        logic signed [CORNER_W-1:0] corner_bottom_left;
        logic signed [CORNER_W-1:0] corner_bottom_right;
        logic signed [CORNER_W-1:0] corner_top_left;
        logic signed [CORNER_W-1:0] corner_top_right;
        logic signed [IDX_W-1:0]    cell_column;
        logic signed [IDX_W-1:0]    cell_row;
    } grid_cell_t;

    typedef struct packed {
        logic signed [IDX_W-1:0] point_column;
        logic signed [IDX_W-1:0] point_row;
        logic [FRAC_W-1:0]       offset_x;
        logic [FRAC_W-1:0]       offset_y;
        logic                    last_point;
    } contour_point_t;

    // biased corners plus crossed-edge mask, bit index = edge_t
    typedef struct packed {
        logic signed [IDX_W-1:0] column;
        logic signed [IDX_W-1:0] row;
        logic [3:0]              crossed;
        logic signed [SUM_W-1:0] bl;
        logic signed [SUM_W-1:0] br;
        logic signed [SUM_W-1:0] tl;
        logic signed [SUM_W-1:0] tr;
    } cell_rec_t;

    typedef struct packed {
        logic signed [IDX_W-1:0] column;
        logic signed [IDX_W-1:0] row;
        edge_t                   side;
        logic                    last;
    } div_tag_t;

    // Endpoint order: ascending edge order, except the top/left pair which
    // starts at the top; saddles visit every edge in ascending order.
    function automatic edge_t edge_sel(input logic [3:0] crossed, input logic [1:0] idx);
        edge_t lo;
        edge_t hi;
        edge_t first;
        edge_t second;
        edge_t sel;
        lo = EDGE_TOP;
        if (crossed[EDGE_RIGHT])
            lo = EDGE_RIGHT;
        if (crossed[EDGE_BOTTOM])
            lo = EDGE_BOTTOM;
        if (crossed[EDGE_LEFT])
            lo = EDGE_LEFT;
        hi = EDGE_LEFT;
        if (crossed[EDGE_BOTTOM])
            hi = EDGE_BOTTOM;
        if (crossed[EDGE_RIGHT])
            hi = EDGE_RIGHT;
        if (crossed[EDGE_TOP])
            hi = EDGE_TOP;
        if (crossed[EDGE_LEFT] && crossed[EDGE_TOP])
        begin
            first  = EDGE_TOP;
            second = EDGE_LEFT;
        end
        else
        begin
            first  = lo;
            second = hi;
        end
        if (&crossed)
            sel = edge_t'(idx);
        else
            sel = idx[0] ? second : first;
        return sel;
    endfunction

endpackage

// ===== hdl/marching_squares_cell_contour.sv =====
// Path: a cell passes the cell queue, the issue registers, the divider stages and
// the point queue; the other endpoints follow one per cycle while queue space allows.
// Throughput: the divider pipeline takes one endpoint per cycle while the point queue
// has credit; cells with no crossing are dropped at the input and never queued.
// Reset: queues empty, divider drained, iso_offset cleared to 0.
// ----------------------------------------------------------------------------
// marching_squares_cell_contour
// Marching-squares contour endpoints per grid cell with linear interpolation.
// ----------------------------------------------------------------------------
module marching_squares_cell_contour
    import mscc_pkg::*;
#(
    parameter int CELL_DEPTH  = CELL_QUEUE_DEPTH,
    parameter int POINT_DEPTH = POINT_QUEUE_DEPTH
)
(
    input  logic                     clk,
    input  logic                     rst_n,
    input  logic                     cfg_valid,
    output logic                     cfg_ready,
    input  logic signed [BIAS_W-1:0] cfg_data,
    input  logic                     push,
    output logic                     full,
    input  grid_cell_t               grid_cell,
    output logic                     empty,
    input  logic                     pop,
    output contour_point_t           contour_point
);

    logic           cell_full;
    logic           cell_push;
    cell_rec_t      cell_rec;
    cell_rec_t      cell_head;
    logic           cell_empty;
    logic           cell_pop;
    logic           res_valid;
    contour_point_t res_point;
    logic           point_full;
    logic           point_pop;

    assign point_pop = pop && !empty;

    mscc_front u_front (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cfg_data  (cfg_data),
        .push      (push),
        .full      (full),
        .grid_cell (grid_cell),
        .cell_full (cell_full),
        .cell_push (cell_push),
        .cell_rec  (cell_rec)
    );

    mscc_fifo #(
        .DATA_W ($bits(cell_rec_t)),
        .DEPTH  (CELL_DEPTH)
    ) u_cell_queue (
        .clk      (clk),
        .rst_n    (rst_n),
        .push     (cell_push),
        .data_in  (cell_rec),
        .full     (cell_full),
        .pop      (cell_pop),
        .data_out (cell_head),
        .empty    (cell_empty)
    );

    mscc_back #(
        .OUT_DEPTH (POINT_DEPTH)
    ) u_back (
        .clk        (clk),
        .rst_n      (rst_n),
        .cell_head  (cell_head),
        .cell_empty (cell_empty),
        .cell_pop   (cell_pop),
        .point_pop  (point_pop),
        .res_valid  (res_valid),
        .res_point  (res_point)
    );

    mscc_fifo #(
        .DATA_W ($bits(contour_point_t)),
        .DEPTH  (POINT_DEPTH)
    ) u_point_queue (
        .clk      (clk),
        .rst_n    (rst_n),
        .push     (res_valid),
        .data_in  (res_point),
        .full     (point_full),
        .pop      (pop),
        .data_out (contour_point),
        .empty    (empty)
    );

    a_no_overflow: assert property (@(posedge clk) disable iff (!rst_n)
        !(res_valid && point_full))
        else $error("result dropped at full point queue");

endmodule

// ===== hdl/mscc_fifo.sv =====
// ----------------------------------------------------------------------------
// mscc_fifo
// Register-file queue with show-ahead read; DEPTH must be a power of two.
// ----------------------------------------------------------------------------
module mscc_fifo
    import mscc_pkg::*;
#(
    parameter int DATA_W = 8,
    parameter int DEPTH  = 4
)
(
    input  logic              clk,
    input  logic              rst_n,
    input  logic              push,
    input  logic [DATA_W-1:0] data_in,
    output logic              full,
    input  logic              pop,
    output logic [DATA_W-1:0] data_out,
    output logic              empty
);

    localparam int AW = $clog2(DEPTH);

    logic [DATA_W-1:0] mem_reg [DEPTH];
    logic [AW:0]       wr_ptr_reg;
    logic [AW:0]       rd_ptr_reg;
    logic [AW:0]       wr_ptr_next;
    logic [AW:0]       rd_ptr_next;
    logic              do_push;
    logic              do_pop;

    assign empty    = (wr_ptr_reg == rd_ptr_reg);
    assign full     = (wr_ptr_reg[AW] != rd_ptr_reg[AW]) &&
                      (wr_ptr_reg[AW-1:0] == rd_ptr_reg[AW-1:0]);
    assign do_push  = push && !full;
    assign do_pop   = pop && !empty;
    assign data_out = mem_reg[rd_ptr_reg[AW-1:0]];

    assign wr_ptr_next = wr_ptr_reg + (AW+1)'(do_push);
    assign rd_ptr_next = rd_ptr_reg + (AW+1)'(do_pop);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (do_push)
            mem_reg[wr_ptr_reg[AW-1:0]] <= data_in;
    end

endmodule

// ===== hdl/mscc_front.sv =====
// ----------------------------------------------------------------------------
// mscc_front
// Holds the iso offset, biases the corners and classifies the cell.
// ----------------------------------------------------------------------------
module mscc_front
    import mscc_pkg::*;
(
    input  logic                     clk,
    input  logic                     rst_n,
    input  logic                     cfg_valid,
    output logic                     cfg_ready,
    input  logic signed [BIAS_W-1:0] cfg_data,
    input  logic                     push,
    output logic                     full,
    input  grid_cell_t               grid_cell,
    input  logic                     cell_full,
    output logic                     cell_push,
    output cell_rec_t                cell_rec
);

    logic signed [BIAS_W-1:0] iso_offset_reg;
    logic signed [SUM_W-1:0]  bias;
    logic [3:0]               sign_ok;

    assign cfg_ready = 1'b1;
    assign full      = cell_full;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            iso_offset_reg <= '0;
        else if (cfg_valid && cfg_ready)
            iso_offset_reg <= cfg_data;
    end

    assign bias = SUM_W'(iso_offset_reg);

    always_comb
    begin
        cell_rec.column = grid_cell.cell_column;
        cell_rec.row    = grid_cell.cell_row;
        cell_rec.bl     = SUM_W'(grid_cell.corner_bottom_left) + bias;
        cell_rec.br     = SUM_W'(grid_cell.corner_bottom_right) + bias;
        cell_rec.tl     = SUM_W'(grid_cell.corner_top_left) + bias;
        cell_rec.tr     = SUM_W'(grid_cell.corner_top_right) + bias;
        sign_ok = {!cell_rec.bl[SUM_W-1], !cell_rec.br[SUM_W-1],
                   !cell_rec.tl[SUM_W-1], !cell_rec.tr[SUM_W-1]};
        cell_rec.crossed[EDGE_LEFT]   = sign_ok[3] ^ sign_ok[1];
        cell_rec.crossed[EDGE_BOTTOM] = sign_ok[3] ^ sign_ok[2];
        cell_rec.crossed[EDGE_RIGHT]  = sign_ok[2] ^ sign_ok[0];
        cell_rec.crossed[EDGE_TOP]    = sign_ok[1] ^ sign_ok[0];
    end

    // cells without a crossing are dropped here
    assign cell_push = push && !cell_full && (cell_rec.crossed != 4'b0000);

endmodule

// ===== hdl/mscc_divider.sv =====
// ----------------------------------------------------------------------------
// mscc_divider
// Pipelined restoring divider, one quotient bit per stage, giving the
// rounded zero-crossing fraction num*4096/den clamped to 0..4096.
// ----------------------------------------------------------------------------
module mscc_divider
    import mscc_pkg::*;
(
    input  logic              clk,
    input  logic              rst_n,
    input  logic              in_valid,
    input  logic [NUM_W-1:0]  in_num,
    input  logic [DEN_W-1:0]  in_den,
    input  div_tag_t          in_tag,
    output logic              out_valid,
    output logic [FRAC_W-1:0] out_quo,
    output div_tag_t          out_tag
);

    localparam int STEPS = FRAC_W;
    localparam int NW    = NUM_W + FRAC_BITS + 1;

    logic [STEPS:0]      valid_reg;
    logic [DEN_W-1:0]    rem_reg  [STEPS+1];
    logic [FRAC_W-1:0]   low_reg  [STEPS+1];
    logic [FRAC_W-1:0]   quo_reg  [STEPS+1];
    logic [DEN_W-1:0]    den_reg  [STEPS+1];
    div_tag_t            tag_reg  [STEPS+1];

    logic [DEN_W:0]      trial    [STEPS];
    logic                ge       [STEPS];
    logic [DEN_W-1:0]    rem_next [STEPS];

    logic [NW-1:0]       dividend;

    assign dividend = {1'b0, in_num, FRAC_BITS'(0)} + NW'(in_den >> 1);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            valid_reg <= '0;
        else
            valid_reg <= {valid_reg[STEPS-1:0], in_valid};
    end

    always_ff @(posedge clk)
    begin
        if (in_valid)
        begin
            rem_reg[0] <= DEN_W'(dividend[NW-1:FRAC_W]);
            low_reg[0] <= dividend[FRAC_W-1:0];
            quo_reg[0] <= '0;
            den_reg[0] <= in_den;
            tag_reg[0] <= in_tag;
        end
    end

    for (genvar k = 0; k < STEPS; k++)
    begin : g_step
        always_comb
        begin
            trial[k]    = {rem_reg[k], low_reg[k][FRAC_W-1]};
            ge[k]       = trial[k] >= {1'b0, den_reg[k]};
            rem_next[k] = ge[k] ? DEN_W'(trial[k] - {1'b0, den_reg[k]})
                                : DEN_W'(trial[k]);
        end

        always_ff @(posedge clk)
        begin
            if (valid_reg[k])
            begin
                rem_reg[k+1] <= rem_next[k];
                low_reg[k+1] <= {low_reg[k][FRAC_W-2:0], 1'b0};
                quo_reg[k+1] <= {quo_reg[k][FRAC_W-2:0], ge[k]};
                den_reg[k+1] <= den_reg[k];
                tag_reg[k+1] <= tag_reg[k];
            end
        end
    end

    always_comb
    begin
        if (den_reg[STEPS] == '0)
            out_quo = FRAC_ZERO;
        else if (quo_reg[STEPS] > FRAC_ONE)
            out_quo = FRAC_ONE;
        else
            out_quo = quo_reg[STEPS];
    end

    assign out_valid = valid_reg[STEPS];
    assign out_tag   = tag_reg[STEPS];

    // numerator never exceeds the denominator on a crossed edge
    a_quo_range: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid && den_reg[STEPS] != '0) |-> quo_reg[STEPS] <= FRAC_ONE)
        else $error("quotient above one");

endmodule

// ===== hdl/mscc_back.sv =====
// ----------------------------------------------------------------------------
// mscc_back
// Walks the crossed edges of the head cell, one endpoint per cycle, feeds
// the divider and builds the result points; credit-limited by queue space.
// ----------------------------------------------------------------------------
module mscc_back
    import mscc_pkg::*;
#(
    parameter int OUT_DEPTH = POINT_QUEUE_DEPTH
)
(
    input  logic           clk,
    input  logic           rst_n,
    input  cell_rec_t      cell_head,
    input  logic           cell_empty,
    output logic           cell_pop,
    input  logic           point_pop,
    output logic           res_valid,
    output contour_point_t res_point
);

    localparam int PEND_W = $clog2(OUT_DEPTH + 1);

    logic [1:0]              pt_idx_reg;
    logic [1:0]              pt_idx_next;
    logic [PEND_W-1:0]       pending_reg;
    logic [PEND_W-1:0]       pending_next;
    logic                    iss_valid_reg;
    logic [NUM_W-1:0]        iss_num_reg;
    logic [DEN_W-1:0]        iss_den_reg;
    div_tag_t                iss_tag_reg;

    logic                    issue;
    logic                    last;
    edge_t                   side;
    logic signed [SUM_W-1:0] op_a;
    logic signed [SUM_W-1:0] op_b;
    logic [SUM_W-1:0]        a_mag;
    logic [SUM_W:0]          diff;
    logic [SUM_W:0]          d_mag;
    div_tag_t                tag;

    logic                    div_valid;
    logic [FRAC_W-1:0]       div_quo;
    div_tag_t                div_tag;

    assign side  = edge_sel(cell_head.crossed, pt_idx_reg);
    assign last  = (&cell_head.crossed) ? (pt_idx_reg == 2'd3) : (pt_idx_reg == 2'd1);
    assign issue = !cell_empty && (pending_reg < PEND_W'(OUT_DEPTH));
    assign cell_pop = issue && last;

    always_comb
    begin
        case (side)
            EDGE_LEFT:
            begin
                op_a = cell_head.bl;
                op_b = cell_head.tl;
            end
            EDGE_BOTTOM:
            begin
                op_a = cell_head.bl;
                op_b = cell_head.br;
            end
            EDGE_RIGHT:
            begin
                op_a = cell_head.br;
                op_b = cell_head.tr;
            end
            default:
            begin
                op_a = cell_head.tl;
                op_b = cell_head.tr;
            end
        endcase
        a_mag = op_a[SUM_W-1] ? (~op_a + 1'b1) : op_a;
        diff  = {op_a[SUM_W-1], op_a} - {op_b[SUM_W-1], op_b};
        d_mag = diff[SUM_W] ? (~diff + 1'b1) : diff;
        tag.column = cell_head.column;
        tag.row    = cell_head.row;
        tag.side   = side;
        tag.last   = last;
    end

    assign pt_idx_next  = issue ? (last ? 2'd0 : pt_idx_reg + 2'd1) : pt_idx_reg;
    assign pending_next = pending_reg + PEND_W'(issue) - PEND_W'(point_pop);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            pt_idx_reg    <= '0;
            pending_reg   <= '0;
            iss_valid_reg <= 1'b0;
        end
        else
        begin
            pt_idx_reg    <= pt_idx_next;
            pending_reg   <= pending_next;
            iss_valid_reg <= issue;
        end
    end

    always_ff @(posedge clk)
    begin
        if (issue)
        begin
            iss_num_reg <= a_mag[NUM_W-1:0];
            iss_den_reg <= d_mag[DEN_W-1:0];
            iss_tag_reg <= tag;
        end
    end

    mscc_divider u_divider (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (iss_valid_reg),
        .in_num    (iss_num_reg),
        .in_den    (iss_den_reg),
        .in_tag    (iss_tag_reg),
        .out_valid (div_valid),
        .out_quo   (div_quo),
        .out_tag   (div_tag)
    );

    always_comb
    begin
        res_point.point_column = div_tag.column;
        res_point.point_row    = div_tag.row;
        res_point.last_point   = div_tag.last;
        case (div_tag.side)
            EDGE_LEFT:
            begin
                res_point.offset_x = FRAC_ZERO;
                res_point.offset_y = div_quo;
            end
            EDGE_BOTTOM:
            begin
                res_point.offset_x = div_quo;
                res_point.offset_y = FRAC_ZERO;
            end
            EDGE_RIGHT:
            begin
                res_point.offset_x = FRAC_ONE;
                res_point.offset_y = div_quo;
            end
            default:
            begin
                res_point.offset_x = div_quo;
                res_point.offset_y = FRAC_ONE;
            end
        endcase
    end

    assign res_valid = div_valid;

    a_credit_bound: assert property (@(posedge clk) disable iff (!rst_n)
        pending_reg <= PEND_W'(OUT_DEPTH))
        else $error("more endpoints in flight than queue space");

endmodule

// ===== sim/tb.sv =====
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb
// Self-checking bench for the marching-squares contour endpoint block.
// A driver feeds grid cells from a queue, a monitor predicts and checks every
// endpoint in order, across several iso offsets and idle/stall patterns.
// ----------------------------------------------------------------------------
module tb;
    import mscc_pkg::*;

    logic                     clk;
    logic                     rst_n;
    logic                     cfg_valid;
    logic                     cfg_ready;
    logic signed [BIAS_W-1:0] cfg_data;
    logic                     push;
    logic                     full;
    grid_cell_t               grid_cell;
    logic                     empty;
    logic                     pop;
    contour_point_t           contour_point;

    grid_cell_t               pending_cells[$];
    contour_point_t           expected_points[$];
    logic signed [BIAS_W-1:0] iso_bias;
    logic                     cell_xfer;
    int                       send_idle_pct;
    int                       recv_stall_pct;
    int                       n_cells;
    int                       n_saddles;
    int                       n_points;
    int                       n_settings;
    int                       n_errors;

    marching_squares_cell_contour u_top (
        .clk           (clk),
        .rst_n         (rst_n),
        .cfg_valid     (cfg_valid),
        .cfg_ready     (cfg_ready),
        .cfg_data      (cfg_data),
        .push          (push),
        .full          (full),
        .grid_cell     (grid_cell),
        .empty         (empty),
        .pop           (pop),
        .contour_point (contour_point)
    );

    initial
    begin
        clk = 1'b0;
    end

    always #6 clk = ~clk;

    task automatic report_mismatch(input string what);
        n_errors++;
        if (n_errors <= 200)
            $display("%0t ERROR: %s", $time, what);
    endtask

    // |a| / |a-b| in Q1.12, round half up, clamp to one
    function automatic logic [FRAC_W-1:0] crossing_frac(input int a, input int b);
        longint num;
        longint den;
        longint q;
        num = (a < 0) ? -longint'(a) : longint'(a);
        den = longint'(a) - longint'(b);
        if (den < 0)
            den = -den;
        if (den == 0)
            return FRAC_ZERO;
        q = (num * 4096 + den / 2) / den;
        if (q > 4096)
            q = 4096;
        return FRAC_W'(q);
    endfunction

    function automatic void predict_endpoints(input grid_cell_t c_in);
        int             bias;
        int             bl;
        int             br;
        int             tl;
        int             tr;
        int             n;
        int             k;
        logic [3:0]     signs;
        edge_t          path[4];
        contour_point_t pt;
        bias = iso_bias;
        bl = c_in.corner_bottom_left;
        bl = bl + bias;
        br = c_in.corner_bottom_right;
        br = br + bias;
        tl = c_in.corner_top_left;
        tl = tl + bias;
        tr = c_in.corner_top_right;
        tr = tr + bias;
        // sign bits: bl br tl tr, set when nonnegative
        signs = {bl >= 0, br >= 0, tl >= 0, tr >= 0};
        n = 2;
        path = '{EDGE_LEFT, EDGE_BOTTOM, EDGE_RIGHT, EDGE_TOP};
        case (signs)
            4'b0000, 4'b1111: n = 0;
            4'b1000, 4'b0111:
            begin
                path[0] = EDGE_LEFT;
                path[1] = EDGE_BOTTOM;
            end
            4'b0100, 4'b1011:
            begin
                path[0] = EDGE_BOTTOM;
                path[1] = EDGE_RIGHT;
            end
            4'b0001, 4'b1110:
            begin
                path[0] = EDGE_RIGHT;
                path[1] = EDGE_TOP;
            end
            4'b0010, 4'b1101:
            begin
                path[0] = EDGE_TOP;
                path[1] = EDGE_LEFT;
            end
            4'b1100, 4'b0011:
            begin
                path[0] = EDGE_LEFT;
                path[1] = EDGE_RIGHT;
            end
            4'b1010, 4'b0101:
            begin
                path[0] = EDGE_BOTTOM;
                path[1] = EDGE_TOP;
            end
            default:          n = 4;
        endcase
        if (n == 4)
            n_saddles++;
        for (k = 0; k < n; k++)
        begin
            pt.point_column = c_in.cell_column;
            pt.point_row    = c_in.cell_row;
            case (path[k])
                EDGE_LEFT:
                begin
                    pt.offset_x = FRAC_ZERO;
                    pt.offset_y = crossing_frac(bl, tl);
                end
                EDGE_BOTTOM:
                begin
                    pt.offset_x = crossing_frac(bl, br);
                    pt.offset_y = FRAC_ZERO;
                end
                EDGE_RIGHT:
                begin
                    pt.offset_x = FRAC_ONE;
                    pt.offset_y = crossing_frac(br, tr);
                end
                default:
                begin
                    pt.offset_x = crossing_frac(tl, tr);
                    pt.offset_y = FRAC_ONE;
                end
            endcase
            pt.last_point = (k == n - 1);
            expected_points.push_back(pt);
        end
    endfunction

    function automatic grid_cell_t make_cell(input int bl, input int br, input int tl,
                                             input int tr, input int col, input int row);
        grid_cell_t c_in;
        c_in.corner_bottom_left  = 16'(bl);
        c_in.corner_bottom_right = 16'(br);
        c_in.corner_top_left     = 16'(tl);
        c_in.corner_top_right    = 16'(tr);
        c_in.cell_column         = 12'(col);
        c_in.cell_row            = 12'(row);
        return c_in;
    endfunction

    // mostly mixed-sign cells; some near the iso level, some at extremes,
    // some with no crossing
    function automatic grid_cell_t random_cell();
        int pick;
        int base;
        int side;
        int v[4];
        pick = $urandom_range(99);
        base = -int'(iso_bias);
        side = $urandom_range(1);
        for (int i = 0; i < 4; i++)
        begin
            if (pick < 60)
                v[i] = int'($urandom_range(65535)) - 32768;
            else if (pick < 85)
                v[i] = base + int'($urandom_range(600)) - 300;
            else if (pick < 95)
            begin
                case ($urandom_range(3))
                    0:       v[i] = -32768;
                    1:       v[i] = 32767;
                    2:       v[i] = base;
                    default: v[i] = base - 1;
                endcase
            end
            else if (side == 1)
                v[i] = base + int'($urandom_range(20000));
            else
                v[i] = base - 1 - int'($urandom_range(20000));
        end
        return make_cell(v[0], v[1], v[2], v[3], int'($urandom_range(1027)) - 2,
                         int'($urandom_range(1027)) - 2);
    endfunction

    task automatic queue_directed();
        int pos;
        int neg;
        for (int sc = 0; sc < 16; sc++)
        begin
            pos = 700 + 211 * sc;
            neg = -(400 + 157 * sc);
            pending_cells.push_back(make_cell(sc[3] ? pos : neg, sc[2] ? pos : neg,
                                              sc[1] ? pos : neg, sc[0] ? pos : neg,
                                              sc * 68 - 2, 1025 - sc * 68));
        end
        pending_cells.push_back(make_cell(-32768, 32767, 32767, -32768, -2, 1025));
        pending_cells.push_back(make_cell(32767, -32768, -32768, 32767, 1025, -2));
        pending_cells.push_back(make_cell(0, -1, 0, -1, 0, 0));
        pending_cells.push_back(make_cell(-1, 0, -1, 0, -1, -1));
        pending_cells.push_back(make_cell(1, -1, -2, 2, 1024, 1023));
        pending_cells.push_back(make_cell(-32768, -32768, -32768, -32768, 5, 6));
        pending_cells.push_back(make_cell(32767, 32767, 32767, 32767, 7, 8));
        pending_cells.push_back(make_cell(-32768, 1, 32767, -1, 1, 2));
    endtask

    task automatic queue_random(input int count);
        repeat (count)
            pending_cells.push_back(random_cell());
    endtask

    // all cells transferred and all endpoints seen, then room for cells
    // that make no endpoint to drain
    task automatic wait_idle();
        while (pending_cells.size() != 0 || push || expected_points.size() != 0)
            @(posedge clk);
        repeat (40)
            @(posedge clk);
    endtask

    task automatic write_iso(input logic signed [BIAS_W-1:0] value);
        wait_idle();
        @(negedge clk);
        cfg_valid <= 1'b1;
        cfg_data  <= value;
        do
            @(posedge clk);
        while (!cfg_ready);
        iso_bias = value;
        n_settings++;
        @(negedge clk);
        cfg_valid <= 1'b0;
    endtask

    always @(negedge clk)
    begin
        if (!rst_n)
        begin
            push <= 1'b0;
            pop  <= 1'b0;
        end
        else
        begin
            if (!push || cell_xfer)
            begin
                if (pending_cells.size() != 0 && $urandom_range(99) >= send_idle_pct)
                begin
                    grid_cell <= pending_cells.pop_front();
                    push      <= 1'b1;
                end
                else
                    push <= 1'b0;
            end
            pop <= ($urandom_range(99) >= recv_stall_pct);
        end
    end

    always @(posedge clk)
    begin
        contour_point_t want;
        cell_xfer <= rst_n && push && !full;
        if (rst_n && pop && !empty)
        begin
            n_points++;
            if (expected_points.size() == 0)
                report_mismatch($sformatf("unexpected endpoint col %0d row %0d x %0d y %0d",
                                          contour_point.point_column,
                                          contour_point.point_row,
                                          contour_point.offset_x, contour_point.offset_y));
            else
            begin
                want = expected_points.pop_front();
                if (contour_point.point_column !== want.point_column ||
                    contour_point.point_row !== want.point_row ||
                    contour_point.offset_x !== want.offset_x ||
                    contour_point.offset_y !== want.offset_y ||
                    contour_point.last_point !== want.last_point)
                    report_mismatch($sformatf(
                        "endpoint got (%0d,%0d,%0d,%0d,%0b) expected (%0d,%0d,%0d,%0d,%0b)",
                        contour_point.point_column, contour_point.point_row,
                        contour_point.offset_x, contour_point.offset_y,
                        contour_point.last_point, want.point_column, want.point_row,
                        want.offset_x, want.offset_y, want.last_point));
            end
        end
        if (rst_n && push && !full)
        begin
            n_cells++;
            predict_endpoints(grid_cell);
        end
    end

    initial
    begin
        rst_n          = 1'b0;
        cfg_valid      = 1'b0;
        cfg_data       = '0;
        push           = 1'b0;
        pop            = 1'b0;
        grid_cell      = '0;
        cell_xfer      = 1'b0;
        iso_bias       = '0;
        send_idle_pct  = 0;
        recv_stall_pct = 0;
        n_cells        = 0;
        n_saddles      = 0;
        n_points       = 0;
        n_settings     = 1;
        n_errors       = 0;
        repeat (10)
            @(negedge clk);
        rst_n = 1'b1;

        queue_directed();

        send_idle_pct  = 51;
        recv_stall_pct = 0;
        write_iso(-13'sd4096);
        queue_random(30);
        wait_idle();
        queue_random(30);

        send_idle_pct  = 0;
        recv_stall_pct = 51;
        write_iso(13'sd4095);
        queue_random(60);

        send_idle_pct  = 9;
        recv_stall_pct = 9;
        write_iso(BIAS_W'($urandom));
        queue_random(60);

        send_idle_pct  = 0;
        recv_stall_pct = 0;
        write_iso(BIAS_W'($urandom));
        queue_random(40);

        wait_idle();
        $display("Run covered %0d cells (%0d saddles) and %0d endpoints", n_cells, n_saddles,
                 n_points);
        $display("across %0d iso offset settings and four idle/stall patterns", n_settings);
        if (n_errors == 0)
            $display("No mismatches found");
        else
            $display("Mismatches found");
        $finish;
    end

    initial
    begin
        #3000000;
        $display("Mismatches found");
        $finish;
    end

endmodule
